### hw/rtl/sorted_priority_queue_defines.svh
// ----------------------------------------------------------------------------
// Sorted priority queue: assertion macros
// Shared concurrent assertion forms for the queue's RTL.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sorted_priority_queue: assertion failed");

// next-cycle implication, disabled during reset
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sorted_priority_queue: assertion failed");

`endif

### hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Sizes, command and status codes, and the types shared by the cells.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

    localparam int DEPTH = 16;
    localparam int PRI_W = 8;
    localparam int PAY_W = 32;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int OCC_W = 5;
    localparam int STATUS_W = 2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [PRI_W-1:0] pri;
        logic [PAY_W-1:0] pay;
    } t_entry;

    typedef struct packed {
        logic   insert;
        logic   remove;
        t_entry new_entry;
    } t_cell_ctl;

endpackage

`default_nettype wire

### hw/rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// One slot of the sorted chain: holds, takes the new entry, or shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell (
    input  wire                     i_clk,
    input  wire spq_pkg::t_cell_ctl i_ctl,
    input  wire                     i_occ,
    input  wire                     i_left_keep,
    input  wire spq_pkg::t_entry    i_left,
    input  wire spq_pkg::t_entry    i_right,
    output logic                    o_keep,
    output spq_pkg::t_entry         o_entry
);
    import spq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // slot stays put on insert when it outranks or ties the new entry
    assign o_keep  = i_occ && (r_entry.pri >= i_ctl.new_entry.pri);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        priority if (i_ctl.remove) begin
            n_entry = i_right;
        end else if (i_ctl.insert && !o_keep) begin
            n_entry = i_left_keep ? i_ctl.new_entry : i_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

`default_nettype wire

### hw/rtl/sorted_priority_queue.sv
// Bounded priority queue of DEPTH entries kept sorted in a row of cells, slot 0 at the
// front. An insert lands behind every entry of equal or higher priority; a remove pops
// slot 0 and the row shifts forward. Every request gives one response: status, the
// popped entry (zero unless a remove succeeded) and the occupancy afterwards. The block
// takes one request per cycle; the response appears in an output register in the cycle after
// acceptance, and a request is taken whenever that register is empty or being
// read. The cycle time is set by the priority compare in each cell feeding its
// neighbor's select.
// ----------------------------------------------------------------------------
// Sorted priority queue top level
// Request handshake, entry count, cell chain and response register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_priority_queue_defines.svh"

module sorted_priority_queue (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_valid,
    output logic                        o_ready,
    input  wire                         i_command,
    input  wire [spq_pkg::PRI_W-1:0]    i_new_priority,
    input  wire [spq_pkg::PAY_W-1:0]    i_new_payload,
    output logic                        o_valid,
    input  wire                         i_ready,
    output logic [spq_pkg::STATUS_W-1:0] o_status,
    output logic [spq_pkg::PAY_W-1:0]   o_popped_payload,
    output logic [spq_pkg::PRI_W-1:0]   o_popped_priority,
    output logic [spq_pkg::OCC_W-1:0]   o_occupancy
);
    import spq_pkg::*;

    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [STATUS_W-1:0] n_status;
    t_entry              r_popped;
    t_entry              n_popped;

    t_cell_ctl           w_ctl;
    t_entry              w_entry [DEPTH];
    logic [DEPTH-1:0]    w_keep;
    logic [DEPTH-1:0]    w_occ;
    logic                w_acc;
    logic                w_full;
    logic                w_empty;

    assign o_ready = !r_out_valid || i_ready;
    assign w_acc   = i_valid && o_ready;
    assign w_full  = (r_count == CNT_W'(DEPTH));
    assign w_empty = (r_count == '0);

    assign w_ctl.insert        = w_acc && (i_command == CMD_INSERT) && !w_full;
    assign w_ctl.remove        = w_acc && (i_command == CMD_REMOVE) && !w_empty;
    assign w_ctl.new_entry.pri = i_new_priority;
    assign w_ctl.new_entry.pay = i_new_payload;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        t_entry w_left;
        t_entry w_right;
        logic   w_left_keep;

        assign w_occ[k] = (CNT_W'(k) < r_count);

        if (k == 0) begin : g_front
            assign w_left_keep = 1'b1;
            assign w_left      = '0;
        end else begin : g_mid
            assign w_left_keep = w_keep[k-1];
            assign w_left      = w_entry[k-1];
        end

        if (k == DEPTH - 1) begin : g_back
            assign w_right = '0;
        end else begin : g_body
            assign w_right = w_entry[k+1];
        end

        spq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_occ       (w_occ[k]),
            .i_left_keep (w_left_keep),
            .i_left      (w_left),
            .i_right     (w_right),
            .o_keep      (w_keep[k]),
            .o_entry     (w_entry[k])
        );
    end

    always_comb begin
        n_count  = r_count;
        n_status = ST_DONE;
        n_popped = '0;
        if (w_acc) begin
            unique case (i_command)
                CMD_INSERT: begin
                    if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                end
                CMD_REMOVE: begin
                    if (w_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_count  = r_count - CNT_W'(1);
                        n_popped = w_entry[0];
                    end
                end
                default: begin
                    n_status = ST_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_acc) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_status <= n_status;
            r_popped <= n_popped;
        end
    end

    logic [CNT_W-1:0] r_out_count;

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_out_count <= n_count;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_status          = r_status;
    assign o_popped_payload  = r_popped.pay;
    assign o_popped_priority = r_popped.pri;
    assign o_occupancy       = OCC_W'(r_out_count);

    `SPQ_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH))

    `SPQ_ASSERT_NEXT(a_insert_grows, i_clk, i_rst_n, w_ctl.insert, r_count == $past(r_count) + CNT_W'(1))

    `SPQ_ASSERT_NOW(a_front_sorted, i_clk, i_rst_n, w_occ[1], w_entry[0].pri >= w_entry[1].pri)

    `SPQ_ASSERT_NOW(a_full_status, i_clk, i_rst_n, o_valid && (o_status == ST_FULL), r_out_count == CNT_W'(DEPTH))

endmodule

`default_nettype wire

### verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted priority queue testbench
// Drives insert and remove requests with random gaps and output back-pressure,
// tracks a shadow copy of the sorted store, and compares every response
// field by field in request order.
// ----------------------------------------------------------------------------

module tb;

    import spq_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PAY_W-1:0]    pay;
        logic [PRI_W-1:0]    pri;
        logic [OCC_W-1:0]    occ;
    } t_response;

    class queue_shadow;
        t_entry    held[DEPTH];
        int        held_count;
        t_response awaiting[$];
        int        errors;
        int        n_insert;
        int        n_remove;
        int        n_full;
        int        n_empty;

        function new();
            held_count = 0;
            errors     = 0;
            n_insert   = 0;
            n_remove   = 0;
            n_full     = 0;
            n_empty    = 0;
        endfunction

        function void note_request(logic cmd, logic [PRI_W-1:0] pri, logic [PAY_W-1:0] pay);
            t_response r;
            int pos;
            int k;
            r = '0;
            if (cmd == CMD_INSERT) begin
                if (held_count >= DEPTH) begin
                    r.status = ST_FULL;
                    n_full++;
                end else begin
                    pos = 0;
                    while (pos < held_count && held[pos].pri >= pri) pos++;
                    for (k = held_count; k > pos; k--) held[k] = held[k-1];
                    held[pos].pri = pri;
                    held[pos].pay = pay;
                    held_count++;
                    r.status = ST_DONE;
                    n_insert++;
                end
            end else begin
                if (held_count == 0) begin
                    r.status = ST_EMPTY;
                    n_empty++;
                end else begin
                    r.status = ST_DONE;
                    r.pri = held[0].pri;
                    r.pay = held[0].pay;
                    for (k = 1; k < held_count; k++) held[k-1] = held[k];
                    held_count--;
                    n_remove++;
                end
            end
            r.occ = OCC_W'(held_count);
            awaiting.push_back(r);
        endfunction

        function void compare_field(string name, longint unsigned want, longint unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            end
        endfunction

        function void check_response(t_response got);
            t_response want;
            if (awaiting.size() == 0) begin
                errors++;
                $display("%0t: unexpected response, expected none, got %0h", $time, got);
            end else begin
                want = awaiting.pop_front();
                compare_field("status", want.status, got.status);
                compare_field("popped_payload", want.pay, got.pay);
                compare_field("popped_priority", want.pri, got.pri);
                compare_field("occupancy", want.occ, got.occ);
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic              i_command;
    logic [PRI_W-1:0]  i_new_priority;
    logic [PAY_W-1:0]  i_new_payload;
    logic              o_valid;
    logic              i_ready;
    logic [STATUS_W-1:0] o_status;
    logic [PAY_W-1:0]  o_popped_payload;
    logic [PRI_W-1:0]  o_popped_priority;
    logic [OCC_W-1:0]  o_occupancy;

    queue_shadow book;
    bit          quiet;
    bit          hold_start;

    sorted_priority_queue dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_command         (i_command),
        .i_new_priority    (i_new_priority),
        .i_new_payload     (i_new_payload),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_status          (o_status),
        .o_popped_payload  (o_popped_payload),
        .o_popped_priority (o_popped_priority),
        .o_occupancy       (o_occupancy)
    );

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [PRI_W-1:0] pick_priority();
        case ($urandom_range(3))
            0: pick_priority = PRI_W'($urandom_range(3));
            1: pick_priority = PRI_W'(255 - $urandom_range(3));
            2: pick_priority = PRI_W'(8 * $urandom_range(4));
            default: pick_priority = PRI_W'($urandom);
        endcase
    endfunction

    task automatic send_request(input logic cmd, input logic [PRI_W-1:0] pri,
                                input logic [PAY_W-1:0] pay);
        @(negedge i_clk);
        while (!quiet && $urandom_range(99) < 18) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_command      <= cmd;
        i_new_priority <= pri;
        i_new_payload  <= pay;
        do @(posedge i_clk); while (!o_ready);
        book.note_request(cmd, pri, pay);
    endtask

    // output side: random stalls plus an occasional long hold-off
    initial begin
        int hold_left;
        hold_left = 0;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_start) begin
                hold_start = 1'b0;
                hold_left  = 80;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= quiet || ($urandom_range(99) >= 18);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            book.check_response({o_status, o_popped_payload, o_popped_priority, o_occupancy});
    end

    initial begin
        #2ms;
        $display("sorted_priority_queue: mismatch");
        $finish;
    end

    initial begin
        int insert_pct;
        int i;
        book           = new();
        quiet          = 1'b0;
        hold_start     = 1'b0;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_command      = CMD_INSERT;
        i_new_priority = '0;
        i_new_payload  = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty remove, extremes, equal priorities, fill, full reject
        send_request(CMD_REMOVE, 8'hff, 32'hffff_ffff);
        send_request(CMD_INSERT, 8'h00, 32'h0000_0000);
        send_request(CMD_INSERT, 8'hff, 32'hffff_ffff);
        send_request(CMD_INSERT, 8'hff, 32'h0000_0001);
        send_request(CMD_INSERT, 8'h00, 32'h0000_0002);
        for (i = 0; i < DEPTH - 4; i++)
            send_request(CMD_INSERT, pick_priority(), $urandom);
        send_request(CMD_INSERT, 8'h80, 32'h5a5a_a5a5);
        for (i = 0; i < 5; i++)
            send_request(CMD_REMOVE, '0, '0);

        // random: insert bias swings so the store fills and drains repeatedly
        insert_pct = 50;
        for (i = 0; i < 1130; i++) begin
            if (i % 40 == 0) begin
                case ($urandom_range(2))
                    0: insert_pct = 85;
                    1: insert_pct = 50;
                    default: insert_pct = 15;
                endcase
            end
            quiet = (i >= 500 && i < 700);
            if (i == 300 || i == 900)
                hold_start = 1'b1;
            if ($urandom_range(99) < insert_pct)
                send_request(CMD_INSERT, pick_priority(), $urandom);
            else
                send_request(CMD_REMOVE, PRI_W'($urandom), $urandom);
        end
        quiet = 1'b0;
        @(negedge i_clk);
        i_valid <= 1'b0;

        while (book.awaiting.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("covered %0d inserts, %0d removes, %0d full rejects, %0d empty removes",
                 book.n_insert, book.n_remove, book.n_full, book.n_empty);
        if (book.errors == 0)
            $display("sorted_priority_queue: match");
        else
            $display("sorted_priority_queue: mismatch");
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/spq_pkg.sv
hw/rtl/spq_cell.sv
hw/rtl/sorted_priority_queue.sv
verif/tb.sv
